FILE: src/abrf_pkg.sv
// Package for the banked register file: widths, storage map, mode codes,
// register numbers and the decoded-request struct. No dependencies.
package abrf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned RamDepth = 31;
  localparam int unsigned RamAddrW = $clog2(RamDepth);

  typedef logic [RamAddrW-1:0] ram_addr_t;
  typedef logic [DataW-1:0]    data_t;
  typedef logic [2:0]          slot_t;

  // CPSR mode codes
  localparam logic [4:0] ModeUsr = 5'h10;
  localparam logic [4:0] ModeFiq = 5'h11;
  localparam logic [4:0] ModeIrq = 5'h12;
  localparam logic [4:0] ModeSvc = 5'h13;
  localparam logic [4:0] ModeAbt = 5'h17;
  localparam logic [4:0] ModeUnd = 5'h1B;
  localparam logic [4:0] ModeSys = 5'h1F;

  // Architectural register numbers
  localparam logic [3:0] RegR7  = 4'd7;
  localparam logic [3:0] RegR12 = 4'd12;
  localparam logic [3:0] RegLr  = 4'd14;
  localparam logic [3:0] RegPc  = 4'd15;

  // R13/R14 bank slots
  localparam slot_t SlotUsr = 3'd0;
  localparam slot_t SlotFiq = 3'd1;
  localparam slot_t SlotIrq = 3'd2;
  localparam slot_t SlotSvc = 3'd3;
  localparam slot_t SlotAbt = 3'd4;
  localparam slot_t SlotUnd = 3'd5;

  // Storage map: R0..R12 normal at 0..12, R8..R12 fiq at 13..17,
  // R13/R14 pairs from 18, PC at 30.
  localparam ram_addr_t FiqOffset = ram_addr_t'(5);
  localparam ram_addr_t StkBase   = ram_addr_t'(18);
  localparam ram_addr_t PcAddr    = ram_addr_t'(30);

  localparam data_t PcAdjust = data_t'(8);

  typedef struct packed {
    logic      wr;
    logic      bad;
    logic      priv;
    logic      is_pc;
    ram_addr_t addr;
  } dec_t;

endpackage

FILE: src/abrf_if.sv
// Request and response channel interfaces for the banked register file.
// Depends on abrf_pkg.
interface abrf_req_if;
  import abrf_pkg::*;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] reg_index;
  logic [4:0] cpu_mode;
  data_t      write_value;

  modport source (output valid, kind, reg_index, cpu_mode, write_value, input ready);
  modport sink   (input valid, kind, reg_index, cpu_mode, write_value, output ready);
endinterface

interface abrf_rsp_if;
  import abrf_pkg::*;
  logic  valid;
  logic  ready;
  data_t read_value;
  logic  bad_mode;
  logic  privileged;

  modport source (output valid, read_value, bad_mode, privileged, input ready);
  modport sink   (input valid, read_value, bad_mode, privileged, output ready);
endinterface

FILE: src/arm_banked_register_file_unit.sv
// Banked ARM register file: one 31-entry synchronous RAM holds every bank.
// Timing: the RAM is read and stage 1 loads at the edge that takes the request;
// the output register loads when stage 1 moves on, and response valid rises with it.
// Throughput: one request per cycle while responses drain.
// Reset: all registers read as zero (PC as 8); per-entry valid bits cleared at once.
// Depends on abrf_pkg, abrf_if, abrf_ram and abrf_decode.
module arm_banked_register_file_unit (
  input  logic clk_i,
  input  logic rst_ni,
  abrf_req_if.sink   req_i,
  abrf_rsp_if.source rsp_o
);
  import abrf_pkg::*;

  // ---- request decode ----
  dec_t dec;

  abrf_decode u_decode (
    .kind_i      (req_i.kind),
    .reg_index_i (req_i.reg_index),
    .cpu_mode_i  (req_i.cpu_mode),
    .dec_o       (dec)
  );

  // ---- pipeline control ----
  // Stage 1 waits for RAM data; the output register holds the response.
  // Stage 1 moves on whenever the output register is free or being taken,
  // so a new request is only refused when both stages are held.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic s1_move;
  logic req_fire;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign req_fire = req_i.valid && req_i.ready;

  // ---- storage ----
  // Never-written entries read as zero through the valid bits.
  logic [RamDepth-1:0] vld_q, vld_d;
  logic                ram_we;
  data_t               ram_rdata;

  assign ram_we = req_fire && dec.wr && !dec.bad;

  abrf_ram #(
    .Width (DataW),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (req_fire),
    .addr_i  (dec.addr),
    .wdata_i (req_i.write_value),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    vld_d = vld_q;
    if (ram_we) begin
      vld_d[dec.addr] = 1'b1;
    end
  end

  // ---- stage 1 ----
  // The RAM keeps its read data while no new request enters, so a held
  // stage 1 still sees the right word.
  dec_t s1_dec_q;
  logic s1_hit_q;

  // ---- response formation ----
  data_t rd_word;
  data_t rd_value;

  assign rd_word = s1_hit_q ? ram_rdata : '0;

  always_comb begin
    if (s1_dec_q.wr || s1_dec_q.bad) begin
      rd_value = '0;
    end else if (s1_dec_q.is_pc) begin
      rd_value = rd_word + PcAdjust;   // PC reads as stored + 8, wraps
    end else begin
      rd_value = rd_word;
    end
  end

  data_t out_value_q;
  logic  out_bad_q;
  logic  out_priv_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_dec_q <= dec;
      s1_hit_q <= vld_q[dec.addr];
    end
    if (s1_move) begin
      out_value_q <= rd_value;
      out_bad_q   <= s1_dec_q.bad;
      out_priv_q  <= s1_dec_q.priv;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.bad_mode   = out_bad_q;
  assign rsp_o.privileged = out_priv_q;

`ifndef SYNTHESIS
  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && dec.bad |-> !ram_we)
    else $error("write issued for a request with no bank");

  a_refuse_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> s1_valid_q && out_valid_q)
    else $error("request refused with a free stage");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_dec_q))
    else $error("stage 1 lost while output held");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_dec_q.bad |=> out_value_q == '0)
    else $error("non-zero read value on bad mode response");
`endif

endmodule

FILE: src/abrf_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module abrf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/abrf_decode.sv
// Request decoder: register number and mode to storage address, plus flags.
// Depends on abrf_pkg.
module abrf_decode (
  input  logic          kind_i,
  input  logic [3:0]    reg_index_i,
  input  logic [4:0]    cpu_mode_i,
  output abrf_pkg::dec_t dec_o
);
  import abrf_pkg::*;

  slot_t     slot;
  logic      slot_ok;
  ram_addr_t stk_addr;

  always_comb begin
    slot_ok = 1'b1;
    case (cpu_mode_i)
      ModeUsr, ModeSys: slot = SlotUsr;
      ModeFiq:          slot = SlotFiq;
      ModeIrq:          slot = SlotIrq;
      ModeSvc:          slot = SlotSvc;
      ModeAbt:          slot = SlotAbt;
      ModeUnd:          slot = SlotUnd;
      default: begin
        slot    = SlotUsr;
        slot_ok = 1'b0;
      end
    endcase
  end

  // pair index: two entries per slot, R14 on the odd one
  assign stk_addr = StkBase + ram_addr_t'({slot, reg_index_i == RegLr});

  always_comb begin
    dec_o.wr    = kind_i;
    dec_o.priv  = (cpu_mode_i != ModeUsr);
    dec_o.bad   = 1'b0;
    dec_o.is_pc = 1'b0;
    dec_o.addr  = ram_addr_t'(reg_index_i);
    if (reg_index_i == RegPc) begin
      dec_o.is_pc = 1'b1;
      dec_o.addr  = PcAddr;
    end else if (reg_index_i > RegR7 && reg_index_i <= RegR12) begin
      if (cpu_mode_i == ModeFiq) begin
        dec_o.addr = ram_addr_t'(reg_index_i) + FiqOffset;
      end
    end else if (reg_index_i > RegR12) begin
      dec_o.addr = stk_addr;
      dec_o.bad  = !slot_ok;
    end
  end

endmodule
